>>> src/frbp_pkg.sv
// Shared types, codes and the backoff function for the failure recovery
// backoff policy block. Used by every module in src; depends on nothing.
`default_nettype none

package frbp_pkg;

	// Depth of the queue between the front and back parts.
	localparam int QDEPTH  = 2;
	localparam int QADDR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Request types.
	localparam logic [1:0] REQ_FRAME   = 2'd0;
	localparam logic [1:0] REQ_FAILURE = 2'd1;
	localparam logic [1:0] REQ_RESULT  = 2'd2;

	// Failure kinds.
	localparam logic [3:0] KIND_NONE         = 4'd0;
	localparam logic [3:0] KIND_DRAWABLE     = 4'd1;
	localparam logic [3:0] KIND_BACKPRESSURE = 4'd2;
	localparam logic [3:0] KIND_RECREATE_LO  = 4'd3;
	localparam logic [3:0] KIND_RECREATE_HI  = 4'd6;

	// Configuration register indexes.
	localparam logic [1:0] CFG_BASE      = 2'd0;
	localparam logic [1:0] CFG_MAX       = 2'd1;
	localparam logic [1:0] CFG_LIMIT     = 2'd2;
	localparam logic [1:0] CFG_MAX_RECR  = 2'd3;

	localparam logic [15:0] TF_TOP = 16'hFFFF;

	typedef enum logic [2:0] {
		ACT_CONTINUE  = 3'd0,
		ACT_RETRY     = 3'd1,
		ACT_SUSPEND   = 3'd2,
		ACT_RECREATE  = 3'd3,
		ACT_TERMINATE = 3'd4
	} act_t;

	// Event classes produced by the front part.
	typedef enum logic [2:0] {
		EV_FRAME,
		EV_TRANSIENT,
		EV_SUSPEND,
		EV_RECREATE,
		EV_TERMINATE,
		EV_RESULT_OK,
		EV_RESULT_FAIL
	} ev_t;

	typedef struct packed {
		logic [15:0] base_backoff_ms;
		logic [15:0] max_backoff_ms;
		logic [15:0] transient_retry_limit;
		logic [7:0]  max_recreation_attempts;
	} cfg_t;

	// Push side of the queue as seen by the front part.
	typedef struct packed {
		logic push;
		ev_t  ev;
	} q_push_t;

	// min(max(base, max), base << (count - 1)), zero when count or base is zero.
	function automatic logic [15:0] backoff_calc(input logic [15:0] count, input cfg_t cfg);
		logic [15:0] ceiling;
		logic [15:0] shift;
		logic [30:0] shifted;
		logic [15:0] result;
		ceiling = (cfg.max_backoff_ms > cfg.base_backoff_ms) ? cfg.max_backoff_ms
		                                                     : cfg.base_backoff_ms;
		shift   = count - 16'd1;
		shifted = {15'd0, cfg.base_backoff_ms} << shift[3:0];
		if (count == 16'd0 || cfg.base_backoff_ms == 16'd0) begin
			result = 16'd0;
		end else if (shift >= 16'd16) begin
			result = ceiling;
		end else if (shifted < {15'd0, ceiling}) begin
			result = shifted[15:0];
		end else begin
			result = ceiling;
		end
		return result;
	endfunction

endpackage

`default_nettype wire

>>> src/frbp_front.sv
// Front part: takes requests and sorts them into event classes for the queue.
// Depends on frbp_pkg.
`default_nettype none

module frbp_front
	import frbp_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] req_type,
	input  wire logic [3:0] failure_kind,
	input  wire logic       surface_visible,
	input  wire logic       recreate_ok,
	input  wire logic       q_full,
	output q_push_t         q_push
);

	ev_t ev;

	always_comb begin
		ev = EV_TERMINATE;
		unique case (req_type)
			REQ_FRAME: ev = EV_FRAME;
			REQ_FAILURE: begin
				unique case (failure_kind) inside
					KIND_DRAWABLE, KIND_BACKPRESSURE:
						ev = surface_visible ? EV_TRANSIENT : EV_SUSPEND;
					[KIND_RECREATE_LO:KIND_RECREATE_HI]: ev = EV_RECREATE;
					default: ev = EV_TERMINATE;
				endcase
			end
			REQ_RESULT: ev = recreate_ok ? EV_RESULT_OK : EV_RESULT_FAIL;
			default: ev = EV_TERMINATE;
		endcase
	end

	assign in_stall   = q_full;
	assign q_push.push = in_valid && !q_full;
	assign q_push.ev   = ev;

endmodule

`default_nettype wire

>>> src/frbp_queue.sv
// Short event queue between the front and back parts.
// Depends on frbp_pkg.
`default_nettype none

module frbp_queue
	import frbp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  q_push_t   q_push,
	output logic      q_full,
	input  wire logic pop,
	output logic      q_valid,
	output ev_t       q_ev
);

	ev_t               mem_q [QDEPTH];
	logic [QADDR_W-1:0] wr_ptr_q;
	logic [QADDR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign q_full  = (count_q == QCNT_W'(QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_ev    = mem_q[rd_ptr_q];
	assign do_push = q_push.push && !q_full;
	assign do_pop  = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= q_push.ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> src/frbp_back.sv
// Back part: keeps the failure counters, decides the action and backoff and
// holds the result register. Depends on frbp_pkg.
`default_nettype none

module frbp_back
	import frbp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  wire logic  q_valid,
	input  ev_t        q_ev,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_stall,
	output logic [2:0] action,
	output logic [15:0] backoff_ms,
	output logic [15:0] transient_count,
	output logic [7:0]  recreation_count
);

	logic [15:0] tf_q;
	logic [7:0]  ra_q;
	logic        pend_q;
	logic        out_valid_q;
	act_t        action_q;
	logic [15:0] backoff_q;

	logic [15:0] tf_d;
	logic [7:0]  ra_d;
	logic        pend_d;
	act_t        act_d;
	logic [15:0] bo_cnt;
	logic        use_bo;
	logic        decide;
	logic [15:0] tf_inc;
	logic [7:0]  ra_inc;
	logic [15:0] bo_d;

	assign pop    = q_valid && (!out_valid_q || !out_stall);
	assign tf_inc = tf_q + 16'd1;
	assign ra_inc = ra_q + 8'd1;

	always_comb begin
		tf_d   = tf_q;
		ra_d   = ra_q;
		pend_d = pend_q;
		act_d  = ACT_TERMINATE;
		bo_cnt = '0;
		use_bo = 1'b0;
		decide = 1'b0;
		unique case (q_ev)
			EV_FRAME: begin
				tf_d   = '0;
				ra_d   = '0;
				pend_d = 1'b0;
				act_d  = ACT_CONTINUE;
			end
			EV_SUSPEND: act_d = ACT_SUSPEND;
			EV_TRANSIENT: begin
				if (tf_q == TF_TOP) begin
					decide = 1'b1;
				end else begin
					tf_d = tf_inc;
					if (tf_inc <= cfg.transient_retry_limit) begin
						act_d  = ACT_RETRY;
						bo_cnt = tf_inc;
						use_bo = 1'b1;
					end else begin
						decide = 1'b1;
					end
				end
			end
			EV_RECREATE: decide = 1'b1;
			EV_RESULT_OK: begin
				pend_d = 1'b0;
				act_d  = ACT_CONTINUE;
			end
			EV_RESULT_FAIL: begin
				if (pend_q) begin
					if (ra_q >= cfg.max_recreation_attempts) begin
						pend_d = 1'b0;
					end else begin
						ra_d   = ra_inc;
						pend_d = 1'b1;
						act_d  = ACT_RECREATE;
						bo_cnt = {8'd0, ra_inc};
						use_bo = 1'b1;
					end
				end
			end
			default: act_d = ACT_TERMINATE;
		endcase

		// Escalation to recreation or termination, shared by transient overflow and recreation kinds.
		if (decide) begin
			if (cfg.max_recreation_attempts == 8'd0 || ra_q >= cfg.max_recreation_attempts) begin
				pend_d = 1'b0;
				act_d  = ACT_TERMINATE;
			end else begin
				ra_d   = ra_inc;
				pend_d = 1'b1;
				tf_d   = '0;
				act_d  = ACT_RECREATE;
				bo_cnt = {8'd0, ra_inc};
				use_bo = 1'b1;
			end
		end

		bo_d = use_bo ? backoff_calc(bo_cnt, cfg) : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tf_q        <= '0;
			ra_q        <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				tf_q   <= tf_d;
				ra_q   <= ra_d;
				pend_q <= pend_d;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			action_q  <= act_d;
			backoff_q <= bo_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign action           = action_q;
	assign backoff_ms       = backoff_q;
	assign transient_count  = tf_q;
	assign recreation_count = ra_q;

`ifndef SYNTHESIS
	a_recreate_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_RECREATE) |-> pend_q)
		else $error("recreate result without pending recreation");
	a_retry_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q == ACT_RETRY) |-> (tf_q != 16'd0))
		else $error("retry result with zero transient count");
	a_backoff_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && action_q != ACT_RETRY && action_q != ACT_RECREATE)
			|-> (backoff_q == 16'd0))
		else $error("backoff on an action that carries none");
`endif

endmodule

`default_nettype wire

>>> src/failure_recovery_backoff_policy.sv
// Top level of the failure recovery backoff policy: configuration registers,
// front classifier, event queue and back decision unit. Depends on frbp_pkg,
// frbp_front, frbp_queue and frbp_back.
//
// Usage: the input channel (in_valid, in_stall) carries one event request per
// transfer: a presented frame, a failure report with surface visibility, or a
// recreation result. The output channel (out_valid, out_stall) returns exactly
// one response per event: the action, the backoff delay in milliseconds and the
// two counters as they stand after the event.
// A request is classified and queued when accepted, taken by the back part
// when its output register is free or taken, and is then shown on the output.
// Throughput is one request per cycle unless the receiver stalls; the back
// part applies one event per cycle, updating the counters in a single step.
// The queue between the parts holds two events, so the input keeps flowing
// until the queue is full while the receiver stalls; after that in_stall rises
// and stays high until the output register is taken.
// Reset (arst_n low) clears the counters, the pending flag, the queue and all
// configuration registers. Configuration is written through cfg_we, cfg_index
// and cfg_wdata while no request is in flight.
`default_nettype none

module failure_recovery_backoff_policy
	import frbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  req_type,
	input  wire logic [3:0]  failure_kind,
	input  wire logic        surface_visible,
	input  wire logic        recreate_ok,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       action,
	output logic [15:0]      backoff_ms,
	output logic [15:0]      transient_count,
	output logic [7:0]       recreation_count
);

	cfg_t    cfg_q;
	q_push_t q_push;
	logic    q_full;
	logic    q_valid;
	ev_t     q_ev;
	logic    pop;

	// Configuration registers; each index writes one field of the struct.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE:     cfg_q.base_backoff_ms         <= cfg_wdata;
				CFG_MAX:      cfg_q.max_backoff_ms          <= cfg_wdata;
				CFG_LIMIT:    cfg_q.transient_retry_limit   <= cfg_wdata;
				CFG_MAX_RECR: cfg_q.max_recreation_attempts <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	frbp_front u_front (
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.req_type        (req_type),
		.failure_kind    (failure_kind),
		.surface_visible (surface_visible),
		.recreate_ok     (recreate_ok),
		.q_full          (q_full),
		.q_push          (q_push)
	);

	frbp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_push  (q_push),
		.q_full  (q_full),
		.pop     (pop),
		.q_valid (q_valid),
		.q_ev    (q_ev)
	);

	frbp_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.q_valid          (q_valid),
		.q_ev             (q_ev),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.backoff_ms       (backoff_ms),
		.transient_count  (transient_count),
		.recreation_count (recreation_count)
	);

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for failure_recovery_backoff_policy: predicts every
// response from its own model of the counters and checks it field by field.
// Depends on frbp_pkg and the RTL in src; reads and writes no files.
`default_nettype none

module testbench;
	import frbp_pkg::*;

	// The request type the block does not define, and the bounds of the
	// terminating failure kinds.
	localparam logic [1:0] REQ_UNUSED    = 2'd3;
	localparam logic [3:0] KIND_FATAL_LO = 4'd7;
	localparam logic [3:0] KIND_FATAL_HI = 4'd15;

	// One event request as it is presented on the input channel.
	typedef struct packed {
		logic [1:0] req;
		logic [3:0] kind;
		logic       visible;
		logic       ok;
	} event_t;

	// One response as the block should return it.
	typedef struct packed {
		act_t        act;
		logic [15:0] delay;
		logic [15:0] streak;
		logic [7:0]  rebuilds;
	} verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_BASE;
	logic [15:0] cfg_wdata = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  req_type = REQ_FRAME;
	logic [3:0]  failure_kind = KIND_NONE;
	logic        surface_visible = 1'b0;
	logic        recreate_ok = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  action;
	logic [15:0] backoff_ms;
	logic [15:0] transient_count;
	logic [7:0]  recreation_count;

	failure_recovery_backoff_policy u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.failure_kind     (failure_kind),
		.surface_visible  (surface_visible),
		.recreate_ok      (recreate_ok),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.backoff_ms       (backoff_ms),
		.transient_count  (transient_count),
		.recreation_count (recreation_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The testbench's own copy of the policy registers. They only change while
	// nothing is in flight, so the driver can read them at any acceptance.
	logic [15:0] set_base = 16'd0;
	logic [15:0] set_max = 16'd0;
	logic [15:0] set_limit = 16'd0;
	logic [7:0]  set_attempts = 8'd0;

	// The testbench's own copy of the policy state.
	logic [15:0] fail_streak = 16'd0;
	logic [7:0]  recreations = 8'd0;
	logic        rebuild_pending = 1'b0;

	event_t   pending_events[$];
	verdict_t awaited_verdicts[$];
	event_t   in_flight;
	verdict_t head;

	int  mismatches = 0;
	int  events_sent = 0;
	int  verdicts_checked = 0;
	int  settings_used = 0;
	int  queued = 0;
	int  action_seen[5];
	int  drv_gap = 0;
	int  mon_hold = 0;
	bit  drv_calm = 1'b0;
	bit  mon_calm = 1'b0;
	bit  steady = 1'b0;

	// Delay for the n-th failure or recreation: the base doubled n - 1 times,
	// capped by the larger of the two backoff registers. A zero count or a
	// zero base turns backoff off altogether.
	function automatic logic [15:0] delay_for(input int unsigned count);
		int unsigned     cap;
		longint unsigned scaled;
		cap = {16'd0, ((set_max > set_base) ? set_max : set_base)};
		if (count == 0 || set_base == 16'd0)
			return 16'd0;
		if (count - 1 >= 16)
			return cap[15:0];
		scaled = {48'd0, set_base};
		scaled = scaled << (count - 1);
		return (scaled < {32'd0, cap}) ? scaled[15:0] : cap[15:0];
	endfunction

	// Either starts another recreation or gives up when the attempts are used.
	function automatic verdict_t rebuild_or_quit();
		verdict_t v;
		v.delay = 16'd0;
		if (set_attempts == 8'd0 || recreations >= set_attempts) begin
			rebuild_pending = 1'b0;
			v.act = ACT_TERMINATE;
		end else begin
			recreations = recreations + 8'd1;
			rebuild_pending = 1'b1;
			fail_streak = 16'd0;
			v.act = ACT_RECREATE;
			v.delay = delay_for(32'(recreations));
		end
		return v;
	endfunction

	// Applies one accepted event to the predicted state and returns the
	// response it must produce.
	function automatic verdict_t apply_event(input event_t ev);
		verdict_t v;
		v.act = ACT_TERMINATE;
		v.delay = 16'd0;
		case (ev.req)
			REQ_FRAME: begin
				fail_streak = 16'd0;
				recreations = 8'd0;
				rebuild_pending = 1'b0;
				v.act = ACT_CONTINUE;
			end
			REQ_FAILURE: begin
				if (ev.kind == KIND_DRAWABLE || ev.kind == KIND_BACKPRESSURE) begin
					if (!ev.visible) begin
						v.act = ACT_SUSPEND;
					end else if (fail_streak == TF_TOP) begin
						// The counter holds at its top and escalates instead.
						v = rebuild_or_quit();
					end else begin
						fail_streak = fail_streak + 16'd1;
						if (fail_streak <= set_limit) begin
							v.act = ACT_RETRY;
							v.delay = delay_for(32'(fail_streak));
						end else begin
							v = rebuild_or_quit();
						end
					end
				end else if (ev.kind >= KIND_RECREATE_LO && ev.kind <= KIND_RECREATE_HI) begin
					v = rebuild_or_quit();
				end
			end
			REQ_RESULT: begin
				if (!rebuild_pending) begin
					v.act = ev.ok ? ACT_CONTINUE : ACT_TERMINATE;
				end else begin
					rebuild_pending = 1'b0;
					if (ev.ok) begin
						v.act = ACT_CONTINUE;
					end else if (recreations < set_attempts) begin
						recreations = recreations + 8'd1;
						rebuild_pending = 1'b1;
						v.act = ACT_RECREATE;
						v.delay = delay_for(32'(recreations));
					end
				end
			end
			default: begin
			end
		endcase
		v.streak = fail_streak;
		v.rebuilds = recreations;
		return v;
	endfunction

	function automatic void add_event(input logic [1:0] req, input logic [3:0] kind,
			input logic visible, input logic ok);
		event_t ev;
		ev.req = req;
		ev.kind = kind;
		ev.visible = visible;
		ev.ok = ok;
		pending_events.push_back(ev);
		queued++;
	endfunction

	// One episode of a stream's life: usually a fresh frame, a run of transient
	// failures that may run past the retry limit, perhaps a failure that asks
	// for recreation outright, then a chain of recreation results that mostly
	// fail. Now and then a few fully random requests follow as noise.
	function automatic void queue_episode();
		int streak;
		int tries;
		int noise;
		int i;
		if ($urandom_range(0, 3) != 0)
			add_event(REQ_FRAME, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		streak = (set_limit < 16'd10) ? set_limit + 2 : 12;
		streak = int'($urandom_range(0, streak));
		for (i = 0; i < streak; i++)
			add_event(REQ_FAILURE,
				($urandom_range(0, 1) != 0) ? KIND_BACKPRESSURE : KIND_DRAWABLE,
				$urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 3) == 0)
			add_event(REQ_FAILURE,
				4'($urandom_range(KIND_RECREATE_LO, KIND_RECREATE_HI)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		tries = ($urandom_range(0, 7) == 0) ? set_attempts + 1 : int'($urandom_range(0, 4));
		for (i = 0; i < tries; i++)
			add_event(REQ_RESULT, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
				(i == tries - 1) ? 1'($urandom_range(0, 1)) : 1'b0);
		if ($urandom_range(0, 3) == 0) begin
			noise = int'($urandom_range(1, 3));
			for (i = 0; i < noise; i++)
				add_event(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end
	endfunction

	// Writes all four policy registers, one per cycle, and updates the
	// testbench's copy. Only called while nothing is in flight.
	task automatic program_policy(input logic [15:0] base, input logic [15:0] ceiling,
			input logic [15:0] limit, input logic [7:0] attempts);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= CFG_MAX;
		cfg_wdata <= ceiling;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_index <= CFG_MAX_RECR;
		cfg_wdata <= {8'd0, attempts};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		set_base = base;
		set_max = ceiling;
		set_limit = limit;
		set_attempts = attempts;
		settings_used++;
	endtask

	// Waits until every queued request has been taken and every response has
	// come back, then lets the pipeline run empty. Sampling on the
	// falling edge keeps clear of the updates made at the rising edge.
	task automatic settle();
		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || awaited_verdicts.size() != 0);
		repeat (6) @(posedge clk);
		@(negedge clk);
	endtask

	// Request driver. The prediction is made at the edge where the request is
	// accepted, so the expected response is queued before it can come out.
	// After each request the driver draws an idle gap; occasionally it flips
	// into a calm mode with no gaps at all.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_verdicts.push_back(apply_event(in_flight));
				events_sent++;
				if ($urandom_range(0, 31) == 0)
					drv_calm = !drv_calm;
				drv_gap = (steady || drv_calm) ? 0 : int'($urandom_range(0, 19));
			end
			// A stalled request stays on the wires unchanged.
			if (!in_valid || !in_stall) begin
				if (drv_gap > 0) begin
					drv_gap--;
					in_valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					in_flight = pending_events.pop_front();
					in_valid <= 1'b1;
					req_type <= in_flight.req;
					failure_kind <= in_flight.kind;
					surface_visible <= in_flight.visible;
					recreate_ok <= in_flight.ok;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor. Every accepted response is matched against the oldest
	// prediction; afterwards the receiver draws how long it stalls.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			mon_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (awaited_verdicts.size() == 0) begin
					$error("unexpected response: action %0d backoff_ms %0d", action, backoff_ms);
					mismatches++;
				end else begin
					head = awaited_verdicts.pop_front();
					verdicts_checked++;
					if (action < 3'd5)
						action_seen[action]++;
					if (action !== head.act) begin
						$error("action: expected %0d, got %0d", head.act, action);
						mismatches++;
					end
					if (backoff_ms !== head.delay) begin
						$error("backoff_ms: expected %0d, got %0d", head.delay, backoff_ms);
						mismatches++;
					end
					if (transient_count !== head.streak) begin
						$error("transient_count: expected %0d, got %0d", head.streak,
							transient_count);
						mismatches++;
					end
					if (recreation_count !== head.rebuilds) begin
						$error("recreation_count: expected %0d, got %0d", head.rebuilds,
							recreation_count);
						mismatches++;
					end
				end
				if ($urandom_range(0, 31) == 0)
					mon_calm = !mon_calm;
				mon_hold = (steady || mon_calm) ? 0 : int'($urandom_range(0, 19));
			end
			if (mon_hold > 0) begin
				mon_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : stimulus
		int          p;
		int          target;
		logic [15:0] base;
		logic [15:0] ceiling;
		logic [15:0] limit;
		logic [7:0]  attempts;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed walk through the policy. With a base of 3, a cap of 20, a
		// limit of three transient failures and two recreations allowed, the
		// backoff doubles, the fourth failure escalates and the second failed
		// recreation gives up. It runs without idling so requests go back to back.
		program_policy(16'd3, 16'd20, 16'd3, 8'd2);
		steady = 1'b1;
		add_event(REQ_FRAME, KIND_NONE, 1'b0, 1'b0);
		add_event(REQ_FAILURE, KIND_NONE, 1'b1, 1'b1);
		add_event(REQ_FAILURE, KIND_DRAWABLE, 1'b0, 1'b0);
		add_event(REQ_FAILURE, KIND_DRAWABLE, 1'b1, 1'b0);
		add_event(REQ_FAILURE, KIND_BACKPRESSURE, 1'b1, 1'b1);
		add_event(REQ_FAILURE, KIND_DRAWABLE, 1'b1, 1'b0);
		add_event(REQ_FAILURE, KIND_BACKPRESSURE, 1'b1, 1'b0);
		add_event(REQ_RESULT, KIND_NONE, 1'b0, 1'b0);
		add_event(REQ_RESULT, KIND_NONE, 1'b0, 1'b0);
		// Results that arrive with no recreation pending.
		add_event(REQ_RESULT, KIND_FATAL_HI, 1'b1, 1'b1);
		add_event(REQ_RESULT, KIND_NONE, 1'b1, 1'b0);
		add_event(REQ_FAILURE, KIND_RECREATE_LO, 1'b1, 1'b0);
		add_event(REQ_FRAME, KIND_FATAL_HI, 1'b1, 1'b1);
		add_event(REQ_FAILURE, KIND_RECREATE_HI, 1'b0, 1'b0);
		add_event(REQ_RESULT, KIND_NONE, 1'b0, 1'b1);
		add_event(REQ_FAILURE, 4'd4, 1'b1, 1'b0);
		add_event(REQ_FAILURE, 4'd5, 1'b1, 1'b0);
		add_event(REQ_FAILURE, KIND_FATAL_LO, 1'b1, 1'b0);
		add_event(REQ_FAILURE, KIND_FATAL_HI, 1'b0, 1'b1);
		add_event(REQ_UNUSED, KIND_FATAL_HI, 1'b1, 1'b1);
		add_event(REQ_UNUSED, KIND_NONE, 1'b0, 1'b0);
		add_event(REQ_FRAME, KIND_NONE, 1'b1, 1'b0);
		settle();
		steady = 1'b0;

		// Random episodes under several settings: all registers at zero, all at
		// their top, a cap below the base, then random ones that favor small
		// limits so the escalation paths are reached often.
		for (p = 0; p < 8; p++) begin
			case (p)
				0: program_policy(16'd0, 16'd0, 16'd0, 8'd0);
				1: program_policy(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
				2: program_policy(16'd1, 16'd0, 16'd2, 8'hFF);
				3: program_policy(16'h8000, 16'h1234, 16'd1, 8'd1);
				default: begin
					base = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(1, 40));
					ceiling = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 400));
					limit = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
						: 16'($urandom_range(0, 6));
					attempts = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
						: 8'($urandom_range(0, 6));
					program_policy(base, ceiling, limit, attempts);
				end
			endcase
			target = queued + 110;
			while (queued < target)
				queue_episode();
			settle();
		end

		$display("Checked %0d responses to %0d requests under %0d register settings,",
			verdicts_checked, events_sent, settings_used);
		$display("seen: continue %0d, retry %0d, suspend %0d, recreate %0d, terminate %0d.",
			action_seen[0], action_seen[1], action_seen[2], action_seen[3], action_seen[4]);
		if (mismatches == 0) begin
			$display("** failure_recovery_backoff_policy: PASSED **");
		end else begin
			$display("** failure_recovery_backoff_policy: FAILED **");
		end
		$finish;
	end

	// Watchdog: set far beyond the slowest correct run.
	initial begin
		#12_000_000;
		$display("** failure_recovery_backoff_policy: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
src/frbp_pkg.sv
src/frbp_front.sv
src/frbp_queue.sv
src/frbp_back.sv
src/failure_recovery_backoff_policy.sv
tb/testbench.sv
